// ----- hdl/utb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 text edit buffer.
// No dependencies; imported by utb_front, utb_back and the top level.
package utb_pkg;

	// Request operation codes as they arrive on the input port.
	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_ERASE  = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NO_ROOM = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	// Code point limits for the encoding lengths.
	localparam logic [20:0] CP_MAX_1B = 21'h00007F;
	localparam logic [20:0] CP_MAX_2B = 21'h0007FF;
	localparam logic [20:0] CP_MAX_3B = 21'h00FFFF;
	localparam logic [20:0] CP_MAX    = 21'h10FFFF;

	// UTF-8 lead and continuation byte marks.
	localparam logic [7:0] LEAD_2B   = 8'hC0;
	localparam logic [7:0] LEAD_3B   = 8'hE0;
	localparam logic [7:0] LEAD_4B   = 8'hF0;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	typedef struct packed {
		logic [1:0]  func;
		logic [20:0] codepoint;
		logic [7:0]  read_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] text_length;
		logic [7:0] read_data;
	} rsp_t;

	// Classified command handed from the front end to the executor.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_APPEND,
		OP_REJECT,
		OP_ERASE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [2:0]      nbytes;
		logic [3:0][7:0] enc;
		logic [7:0]      read_index;
	} cmd_t;

endpackage

// ----- hdl/utb_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module utb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/utb_fifo.sv -----
`timescale 1ns / 1ps
// Small register FIFO with full/empty flags and first-word fall-through.
// No dependencies; used for the command and result queues.
module utb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             wr_ok;
	logic             rd_ok;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_ok = wr && !full;
	assign rd_ok = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_ok, rd_ok})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hdl/utb_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and encodes code points.
// Depends on utb_pkg and utb_fifo (command queue).
module utb_front import utb_pkg::*; #(
	parameter int CMD_DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic push,
	output logic full,
	output cmd_t cmd,
	output logic cmd_valid,
	input  logic cmd_take
);

	cmd_t                 cls;
	logic [$bits(cmd_t)-1:0] cmd_bits;
	logic                 cmd_empty;

	// Classify and encode; the room check needs the byte count and is left to the back end.
	always_comb begin
		cls            = '0;
		cls.op         = OP_NOP;
		cls.read_index = req.read_index;
		unique case (req.func)
			FUNC_APPEND: begin
				if (req.codepoint > CP_MAX) begin
					cls.op = OP_REJECT;
				end else begin
					cls.op = OP_APPEND;
					if (req.codepoint <= CP_MAX_1B) begin
						cls.enc[0] = {1'b0, req.codepoint[6:0]};
						cls.nbytes = 3'd1;
					end else if (req.codepoint <= CP_MAX_2B) begin
						cls.enc[0] = LEAD_2B | {3'b0, req.codepoint[10:6]};
						cls.enc[1] = CONT_TAG | {2'b0, req.codepoint[5:0]};
						cls.nbytes = 3'd2;
					end else if (req.codepoint <= CP_MAX_3B) begin
						cls.enc[0] = LEAD_3B | {4'b0, req.codepoint[15:12]};
						cls.enc[1] = CONT_TAG | {2'b0, req.codepoint[11:6]};
						cls.enc[2] = CONT_TAG | {2'b0, req.codepoint[5:0]};
						cls.nbytes = 3'd3;
					end else begin
						cls.enc[0] = LEAD_4B | {5'b0, req.codepoint[20:18]};
						cls.enc[1] = CONT_TAG | {2'b0, req.codepoint[17:12]};
						cls.enc[2] = CONT_TAG | {2'b0, req.codepoint[11:6]};
						cls.enc[3] = CONT_TAG | {2'b0, req.codepoint[5:0]};
						cls.nbytes = 3'd4;
					end
				end
			end
			FUNC_ERASE: cls.op = OP_ERASE;
			FUNC_READ:  cls.op = OP_READ;
			default:    cls.op = OP_NOP;
		endcase
	end

	utb_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (cls),
		.full   (full),
		.rd     (cmd_take),
		.rdata  (cmd_bits),
		.empty  (cmd_empty)
	);

	assign cmd       = cmd_t'(cmd_bits);
	assign cmd_valid = !cmd_empty;

endmodule

// ----- hdl/utb_back.sv -----
`timescale 1ns / 1ps
// Back end: executes commands against the text store and queues results.
// Depends on utb_pkg, utb_ram (text store) and utb_fifo (result queue).
module utb_back import utb_pkg::*; #(
	parameter int BUFFER_BYTES = 256,
	parameter int RSP_DEPTH    = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_take,
	output rsp_t rsp,
	output logic empty,
	input  logic pop
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int LW = (AW > 8) ? AW : 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPEND,
		S_ERASE,
		S_READ,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [3:0][7:0] enc_q;
	logic [2:0]      nbytes_q;
	logic [1:0]      k_q;
	logic [AW-1:0]   pos_q;
	logic [AW-1:0]   count_q;
	logic [1:0]      status_q;
	logic [7:0]      data_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic [AW:0]   room_sum;
	logic          no_room;
	logic          idx_beyond;
	logic          is_cont;
	logic          last_byte;
	logic          rsp_push;
	logic          rsp_full;
	logic [LW-1:0] len_ext;
	rsp_t          rsp_d;
	logic [$bits(rsp_t)-1:0] rsp_bits;

	assign room_sum   = {1'b0, count_q} + (AW + 1)'(cmd.nbytes);
	assign no_room    = room_sum > (AW + 1)'(BUFFER_BYTES - 1);
	assign idx_beyond = LW'(cmd.read_index) >= LW'(count_q);
	assign is_cont    = (ram_rdata & CONT_MASK) == CONT_TAG;
	assign last_byte  = (3'(k_q) + 3'd1) == nbytes_q;
	assign cmd_take   = (state_q == S_IDLE) && cmd_valid;
	assign rsp_push   = (state_q == S_DONE) && !rsp_full;

	assign ram_we    = (state_q == S_APPEND);
	assign ram_waddr = count_q + AW'(k_q);
	assign ram_wdata = enc_q[k_q];

	// Erase reads one byte ahead so the scan steps one byte per cycle.
	always_comb begin
		if (state_q == S_ERASE) begin
			ram_raddr = pos_q - 1'b1;
		end else if (cmd.op == OP_ERASE) begin
			ram_raddr = count_q - 1'b1;
		end else begin
			ram_raddr = AW'(cmd.read_index);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			enc_q    <= '0;
			nbytes_q <= '0;
			k_q      <= '0;
			pos_q    <= '0;
			count_q  <= '0;
			status_q <= ST_DONE;
			data_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						status_q <= ST_DONE;
						data_q   <= '0;
						unique case (cmd.op)
							OP_APPEND: begin
								if (no_room) begin
									status_q <= ST_NO_ROOM;
									state_q  <= S_DONE;
								end else begin
									enc_q    <= cmd.enc;
									nbytes_q <= cmd.nbytes;
									k_q      <= '0;
									state_q  <= S_APPEND;
								end
							end
							OP_REJECT: begin
								status_q <= ST_INVALID;
								state_q  <= S_DONE;
							end
							OP_ERASE: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									pos_q   <= count_q - 1'b1;
									state_q <= S_ERASE;
								end
							end
							OP_READ: begin
								if (idx_beyond) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_READ;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_APPEND: begin
					if (last_byte) begin
						count_q <= count_q + AW'(nbytes_q);
						state_q <= S_DONE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_ERASE: begin
					if (pos_q != '0 && is_cont) begin
						pos_q <= pos_q - 1'b1;
					end else begin
						count_q <= pos_q;
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					data_q  <= ram_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	utb_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_BYTES)
	) u_text_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign len_ext           = LW'(count_q);
	assign rsp_d.status      = status_q;
	assign rsp_d.text_length = len_ext[7:0];
	assign rsp_d.read_data   = data_q;

	utb_fifo #(
		.WIDTH ($bits(rsp_t)),
		.DEPTH (RSP_DEPTH)
	) u_rsp_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rsp_push),
		.wdata  (rsp_d),
		.full   (rsp_full),
		.rd     (pop),
		.rdata  (rsp_bits),
		.empty  (empty)
	);

	assign rsp = rsp_t'(rsp_bits);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= AW'(BUFFER_BYTES - 1))
		else $error("byte count above capacity");

	a_write_in_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, ram_waddr} < (AW + 1)'(BUFFER_BYTES - 1)))
		else $error("text write beyond capacity");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> ($past(state_q == S_APPEND) || $past(state_q == S_ERASE)))
		else $error("byte count changed outside append or erase");

	a_erase_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERASE) |-> (pos_q < count_q))
		else $error("erase scan above stored length");

	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_push |=> (state_q == S_IDLE))
		else $error("executor not idle after result");

endmodule

// ----- hdl/utf8_text_edit_buffer.sv -----
`timescale 1ns / 1ps
// UTF-8 line-edit buffer: holds up to BUFFER_BYTES-1 bytes of text in one byte-wide
// RAM and serves one request at a time: append a code point (encoded to 1-4 bytes,
// rejected whole when it does not fit, flagged when above U+10FFFF), erase the last
// character (step back over continuation bytes, never below index 0), or read one
// byte. Every request yields one result with status, resulting length and read data.
// Requests enter a two-entry command queue after classification, so push keeps
// working while the executor is busy; results wait in a two-entry result queue.
// The executor takes a new request only when it is through with the last one: an
// append writes its bytes one after another through the text RAM write port, an
// erase reads back over continuation bytes, a read fetches its byte, and rejected
// or no-room requests go straight to their result, which waits for queue room.
// The text RAM needs no clearing after reset: only written positions are read.
//
// Depends on utb_pkg, utb_front and utb_back.
module utf8_text_edit_buffer import utb_pkg::*; #(
	parameter int BUFFER_BYTES = 256,
	parameter int CMD_DEPTH    = 2,
	parameter int RSP_DEPTH    = 2
) (
	input  logic clk,
	input  logic arst_n,
	// request side
	input  req_t req,
	input  logic push,
	output logic full,
	// result side
	output rsp_t rsp,
	output logic empty,
	input  logic pop
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;

	// Classify and encode requests; hold them in the command queue.
	utb_front #(
		.CMD_DEPTH (CMD_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take)
	);

	// Execute against the text store; advance results into the result queue.
	utb_back #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.RSP_DEPTH    (RSP_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.rsp       (rsp),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
